// ===== rtl/cpcr_pkg.sv =====
// cpcr_pkg: transaction types, context record and fixed widths for the
// circle pair contact resolver; no dependencies
`default_nettype none
package cpcr_pkg;

  localparam int unsigned SW  = 33;        // relative position / velocity
  localparam int unsigned AW  = 66;        // a, |b|, c
  localparam int unsigned HW  = 33;        // half of AW for split products
  localparam int unsigned DW  = 132;       // b^2, a*c, discriminant
  localparam int unsigned QW  = 66;        // square root
  localparam int unsigned RMW = QW + 2;    // square root remainder
  localparam int unsigned TW  = 31;        // contact time
  localparam int unsigned RW  = AW + TW;   // divider remainder
  localparam int unsigned MW  = 63;        // |v| * t

  typedef struct packed {
    logic signed [31:0] first_pos_x;
    logic signed [31:0] first_pos_y;
    logic signed [31:0] first_vel_x;
    logic signed [31:0] first_vel_y;
    logic        [30:0] first_radius;
    logic signed [31:0] second_pos_x;
    logic signed [31:0] second_pos_y;
    logic signed [31:0] second_vel_x;
    logic signed [31:0] second_vel_y;
    logic        [30:0] second_radius;
  } in_t;

  typedef struct packed {
    logic               contact;
    logic               overlapping;
    logic        [30:0] contact_time;
    logic signed [31:0] new_first_x;
    logic signed [31:0] new_first_y;
    logic signed [31:0] new_second_x;
    logic signed [31:0] new_second_y;
  } out_t;

  // per-transaction data riding alongside the arithmetic
  typedef struct packed {
    logic signed [31:0] p1x;
    logic signed [31:0] p1y;
    logic signed [31:0] p2x;
    logic signed [31:0] p2y;
    logic signed [32:0] vx;
    logic signed [32:0] vy;
    logic               overlap;
    logic               live;
  } ctx_t;

  function automatic logic [31:0] mag33(input logic signed [32:0] x);
    logic signed [32:0] n;
    n = -x;
    return x[32] ? n[31:0] : x[31:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [64:0] x);
    logic signed [31:0] r;
    if (!x[64] && (|x[63:31])) begin
      r = 32'sh7fffffff;
    end else if (x[64] && !(&x[63:31])) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/cpcr_front.sv =====
// cpcr_front: differences, products, classification and discriminant
// over seven register stages; depends on cpcr_pkg
`default_nettype none
module cpcr_front (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 valid_i,
  input  wire cpcr_pkg::in_t        in_i,
  output logic                      valid_o,
  output cpcr_pkg::ctx_t            ctx_o,
  output logic [cpcr_pkg::AW-1:0]   a_o,
  output logic [cpcr_pkg::AW-1:0]   bm_o,
  output logic [cpcr_pkg::DW-1:0]   d_o
);
  import cpcr_pkg::*;

  logic [7:1] v_q;
  ctx_t c1_q, c2_q, c3_q, c4_q, c5_q, c6_q, c7_q;

  // stage 1: relative terms
  logic signed [SW-1:0] sx1_q, sy1_q;
  logic [31:0] rs1_q;
  ctx_t c1_d;

  always_comb begin
    c1_d.p1x = in_i.first_pos_x;
    c1_d.p1y = in_i.first_pos_y;
    c1_d.p2x = in_i.second_pos_x;
    c1_d.p2y = in_i.second_pos_y;
    c1_d.vx  = $signed({in_i.first_vel_x[31], in_i.first_vel_x})
             - $signed({in_i.second_vel_x[31], in_i.second_vel_x});
    c1_d.vy  = $signed({in_i.first_vel_y[31], in_i.first_vel_y})
             - $signed({in_i.second_vel_y[31], in_i.second_vel_y});
    c1_d.overlap = 1'b0;
    c1_d.live    = 1'b0;
  end

  always_ff @(posedge clk_i) begin
    c1_q  <= c1_d;
    sx1_q <= $signed({in_i.first_pos_x[31], in_i.first_pos_x})
           - $signed({in_i.second_pos_x[31], in_i.second_pos_x});
    sy1_q <= $signed({in_i.first_pos_y[31], in_i.first_pos_y})
           - $signed({in_i.second_pos_y[31], in_i.second_pos_y});
    rs1_q <= {1'b0, in_i.first_radius} + {1'b0, in_i.second_radius};
  end

  // stage 2: squares and dot products
  logic [63:0] sxx2_q, syy2_q, vxx2_q, vyy2_q, rr2_q;
  logic signed [65:0] vsx2_q, vsy2_q;
  logic [31:0] sxa, sya, vxa, vya;

  assign sxa = mag33(sx1_q);
  assign sya = mag33(sy1_q);
  assign vxa = mag33(c1_q.vx);
  assign vya = mag33(c1_q.vy);

  always_ff @(posedge clk_i) begin
    c2_q   <= c1_q;
    sxx2_q <= sxa * sxa;
    syy2_q <= sya * sya;
    vxx2_q <= vxa * vxa;
    vyy2_q <= vya * vya;
    rr2_q  <= rs1_q * rs1_q;
    vsx2_q <= c1_q.vx * sx1_q;
    vsy2_q <= c1_q.vy * sy1_q;
  end

  // stage 3: sums
  logic [64:0] ss3_q, a3_q;
  logic [63:0] rr3_q;
  logic signed [66:0] b3_q;

  always_ff @(posedge clk_i) begin
    c3_q  <= c2_q;
    ss3_q <= {1'b0, sxx2_q} + {1'b0, syy2_q};
    a3_q  <= {1'b0, vxx2_q} + {1'b0, vyy2_q};
    rr3_q <= rr2_q;
    b3_q  <= $signed({vsx2_q[65], vsx2_q}) + $signed({vsy2_q[65], vsy2_q});
  end

  // stage 4: overlap test, approach test, c and |b|
  logic [AW-1:0] a4_q, c4v_q, bm4_q;
  logic ovl4;
  logic signed [66:0] nb3;
  ctx_t c4_d;

  assign ovl4 = ss3_q < {1'b0, rr3_q};
  assign nb3  = -b3_q;

  always_comb begin
    c4_d         = c3_q;
    c4_d.overlap = ovl4;
    c4_d.live    = !ovl4 && b3_q[66] && (a3_q != '0);
  end

  always_ff @(posedge clk_i) begin
    c4_q  <= c4_d;
    a4_q  <= {1'b0, a3_q};
    c4v_q <= {1'b0, ss3_q - {1'b0, rr3_q}};
    bm4_q <= nb3[AW-1:0];
  end

  // stage 5: partial products of b^2 and a*c
  logic [2*HW-1:0] bhh5_q, bhl5_q, bll5_q, ahch5_q, ahcl5_q, alch5_q, alcl5_q;
  logic [AW-1:0] a5_q, bm5_q;

  always_ff @(posedge clk_i) begin
    c5_q    <= c4_q;
    a5_q    <= a4_q;
    bm5_q   <= bm4_q;
    bhh5_q  <= bm4_q[AW-1:HW] * bm4_q[AW-1:HW];
    bhl5_q  <= bm4_q[AW-1:HW] * bm4_q[HW-1:0];
    bll5_q  <= bm4_q[HW-1:0] * bm4_q[HW-1:0];
    ahch5_q <= a4_q[AW-1:HW] * c4v_q[AW-1:HW];
    ahcl5_q <= a4_q[AW-1:HW] * c4v_q[HW-1:0];
    alch5_q <= a4_q[HW-1:0] * c4v_q[AW-1:HW];
    alcl5_q <= a4_q[HW-1:0] * c4v_q[HW-1:0];
  end

  // stage 6: recombine
  logic [DW-1:0] b26_q, ac6_q;
  logic [AW-1:0] a6_q, bm6_q;

  always_ff @(posedge clk_i) begin
    c6_q  <= c5_q;
    a6_q  <= a5_q;
    bm6_q <= bm5_q;
    b26_q <= {bhh5_q, 66'b0} + {32'b0, bhl5_q, 34'b0} + {66'b0, bll5_q};
    ac6_q <= {ahch5_q, 66'b0} + {33'b0, ahcl5_q, 33'b0}
           + {33'b0, alch5_q, 33'b0} + {66'b0, alcl5_q};
  end

  // stage 7: discriminant sign and value
  logic live7;
  ctx_t c7_d;
  logic [DW-1:0] d7_q;
  logic [AW-1:0] a7_q, bm7_q;

  assign live7 = c6_q.live && (b26_q >= ac6_q);

  always_comb begin
    c7_d      = c6_q;
    c7_d.live = live7;
  end

  always_ff @(posedge clk_i) begin
    c7_q  <= c7_d;
    a7_q  <= a6_q;
    bm7_q <= bm6_q;
    d7_q  <= live7 ? (b26_q - ac6_q) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[6:1], valid_i};
    end
  end

  assign valid_o = v_q[7];
  assign ctx_o   = c7_q;
  assign a_o     = a7_q;
  assign bm_o    = bm7_q;
  assign d_o     = d7_q;

endmodule
`default_nettype wire

// ===== rtl/cpcr_sqrt.sv =====
// cpcr_sqrt: pipelined restoring integer square root, one root bit per
// stage; depends on cpcr_pkg
`default_nettype none
module cpcr_sqrt (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 valid_i,
  input  wire cpcr_pkg::ctx_t       ctx_i,
  input  wire logic [cpcr_pkg::AW-1:0] a_i,
  input  wire logic [cpcr_pkg::AW-1:0] bm_i,
  input  wire logic [cpcr_pkg::DW-1:0] d_i,
  output logic                      valid_o,
  output cpcr_pkg::ctx_t            ctx_o,
  output logic [cpcr_pkg::AW-1:0]   a_o,
  output logic [cpcr_pkg::AW-1:0]   bm_o,
  output logic [cpcr_pkg::QW-1:0]   root_o
);
  import cpcr_pkg::*;

  logic           vld_q [QW];
  ctx_t           cx_q  [QW];
  logic [AW-1:0]  a_q   [QW];
  logic [AW-1:0]  bm_q  [QW];
  logic [DW-1:0]  d_q   [QW];
  logic [QW-1:0]  root_q[QW];
  logic [RMW-1:0] rem_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int unsigned Bit = QW - 1 - k;
    logic           vld_s;
    ctx_t           cx_s;
    logic [AW-1:0]  a_s, bm_s;
    logic [DW-1:0]  d_s;
    logic [QW-1:0]  root_s;
    logic [RMW-1:0] rem_s, rem_sh, trial;
    logic           ge;

    if (k == 0) begin : g_src_in
      assign vld_s  = valid_i;
      assign cx_s   = ctx_i;
      assign a_s    = a_i;
      assign bm_s   = bm_i;
      assign d_s    = d_i;
      assign root_s = '0;
      assign rem_s  = '0;
    end else begin : g_src_reg
      assign vld_s  = vld_q[k-1];
      assign cx_s   = cx_q[k-1];
      assign a_s    = a_q[k-1];
      assign bm_s   = bm_q[k-1];
      assign d_s    = d_q[k-1];
      assign root_s = root_q[k-1];
      assign rem_s  = rem_q[k-1];
    end

    // bring down two radicand bits, try root*4+1
    assign rem_sh = {rem_s[RMW-3:0], d_s[2*Bit+1 -: 2]};
    assign trial  = {root_s, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk_i) begin
      cx_q[k]   <= cx_s;
      a_q[k]    <= a_s;
      bm_q[k]   <= bm_s;
      d_q[k]    <= d_s;
      root_q[k] <= {root_s[QW-2:0], ge};
      rem_q[k]  <= ge ? (rem_sh - trial) : rem_sh;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_s;
      end
    end
  end

  assign valid_o = vld_q[QW-1];
  assign ctx_o   = cx_q[QW-1];
  assign a_o     = a_q[QW-1];
  assign bm_o    = bm_q[QW-1];
  assign root_o  = root_q[QW-1];

endmodule
`default_nettype wire

// ===== rtl/cpcr_div.sv =====
// cpcr_div: numerator setup, saturation test and pipelined restoring
// division for the contact time; depends on cpcr_pkg
`default_nettype none
module cpcr_div #(
  parameter int unsigned FracBits = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 valid_i,
  input  wire cpcr_pkg::ctx_t       ctx_i,
  input  wire logic [cpcr_pkg::AW-1:0] a_i,
  input  wire logic [cpcr_pkg::AW-1:0] bm_i,
  input  wire logic [cpcr_pkg::QW-1:0] root_i,
  output logic                      valid_o,
  output cpcr_pkg::ctx_t            ctx_o,
  output logic                      sat_o,
  output logic [cpcr_pkg::TW-1:0]   quo_o
);
  import cpcr_pkg::*;

  localparam int unsigned PadW = RW - AW - FracBits;

  // setup stage: num = (|b| - root) << frac, saturate when num >= a << 31
  logic [AW-1:0] diff;
  logic [RW-1:0] num, lim;
  logic          n_v_q, n_sat_q;
  ctx_t          n_cx_q;
  logic [AW-1:0] n_a_q;
  logic [RW-1:0] n_rem_q;

  assign diff = bm_i - root_i;
  assign num  = {{PadW{1'b0}}, diff, {FracBits{1'b0}}};
  assign lim  = {a_i, {TW{1'b0}}};

  always_ff @(posedge clk_i) begin
    n_cx_q  <= ctx_i;
    n_a_q   <= a_i;
    n_rem_q <= num;
    n_sat_q <= num >= lim;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_v_q <= 1'b0;
    end else begin
      n_v_q <= valid_i;
    end
  end

  logic          vld_q [TW];
  ctx_t          cx_q  [TW];
  logic          sat_q [TW];
  logic [AW-1:0] a_q   [TW];
  logic [RW-1:0] rem_q [TW];
  logic [TW-1:0] quo_q [TW];

  for (genvar k = 0; k < TW; k++) begin : g_stage
    localparam int unsigned Bit = TW - 1 - k;
    logic          vld_s, sat_s, ge;
    ctx_t          cx_s;
    logic [AW-1:0] a_s;
    logic [RW-1:0] rem_s, sub;
    logic [TW-1:0] quo_s;

    if (k == 0) begin : g_src_in
      assign vld_s = n_v_q;
      assign cx_s  = n_cx_q;
      assign sat_s = n_sat_q;
      assign a_s   = n_a_q;
      assign rem_s = n_rem_q;
      assign quo_s = '0;
    end else begin : g_src_reg
      assign vld_s = vld_q[k-1];
      assign cx_s  = cx_q[k-1];
      assign sat_s = sat_q[k-1];
      assign a_s   = a_q[k-1];
      assign rem_s = rem_q[k-1];
      assign quo_s = quo_q[k-1];
    end

    assign sub = {{TW{1'b0}}, a_s} << Bit;
    assign ge  = rem_s >= sub;

    always_ff @(posedge clk_i) begin
      cx_q[k]  <= cx_s;
      sat_q[k] <= sat_s;
      a_q[k]   <= a_s;
      rem_q[k] <= ge ? (rem_s - sub) : rem_s;
      quo_q[k] <= {quo_s[TW-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_s;
      end
    end
  end

  assign valid_o = vld_q[TW-1];
  assign ctx_o   = cx_q[TW-1];
  assign sat_o   = sat_q[TW-1];
  assign quo_o   = quo_q[TW-1];

endmodule
`default_nettype wire

// ===== rtl/circle_pair_contact_resolve_top.sv =====
// start to done runs through the front, root, divide and offset stages
// throughput: one transaction per cycle; busy_o is never raised
// the pipeline depth is set by the bit-per-stage square root and divider
// results are strobed on done_o for one cycle; the receiver cannot stall
// reset: rst_ni async active low clears all stage valid bits
// depends on cpcr_pkg, cpcr_front, cpcr_sqrt, cpcr_div
`default_nettype none
module circle_pair_contact_resolve_top #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  output logic                busy_o,
  input  wire cpcr_pkg::in_t  in_i,
  output logic                done_o,
  output cpcr_pkg::out_t      res_o
);
  import cpcr_pkg::*;

  // fully pipelined, so a transaction is taken in every cycle
  assign busy_o = 1'b0;

  // front end: s, v, a, |b|, c, overlap and discriminant
  logic          f_v;
  ctx_t          f_cx;
  logic [AW-1:0] f_a, f_bm;
  logic [DW-1:0] f_d;

  cpcr_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i),
    .in_i    (in_i),
    .valid_o (f_v),
    .ctx_o   (f_cx),
    .a_o     (f_a),
    .bm_o    (f_bm),
    .d_o     (f_d)
  );

  // floor square root of the discriminant
  logic          r_v;
  ctx_t          r_cx;
  logic [AW-1:0] r_a, r_bm;
  logic [QW-1:0] r_root;

  cpcr_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (f_v),
    .ctx_i   (f_cx),
    .a_i     (f_a),
    .bm_i    (f_bm),
    .d_i     (f_d),
    .valid_o (r_v),
    .ctx_o   (r_cx),
    .a_o     (r_a),
    .bm_o    (r_bm),
    .root_o  (r_root)
  );

  // t = floor(((|b| - root) << frac) / a), with saturation flag
  logic          q_v, q_sat;
  ctx_t          q_cx;
  logic [TW-1:0] q_quo;

  cpcr_div #(
    .FracBits (FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (r_v),
    .ctx_i   (r_cx),
    .a_i     (r_a),
    .bm_i    (r_bm),
    .root_i  (r_root),
    .valid_o (q_v),
    .ctx_o   (q_cx),
    .sat_o   (q_sat),
    .quo_o   (q_quo)
  );

  // offset stage 1: pick the final time and form |v| * t
  logic [TW-1:0] t_d;
  logic [MW-1:0] mx_d, my_d;
  logic          o1_v_q;
  ctx_t          o1_cx_q;
  logic [TW-1:0] o1_t_q;
  logic [MW-1:0] mx_q, my_q;

  // no approach and overlap both give time zero
  assign t_d  = !q_cx.live ? '0 : (q_sat ? {TW{1'b1}} : q_quo);
  assign mx_d = mag33(q_cx.vx) * t_d;
  assign my_d = mag33(q_cx.vy) * t_d;

  always_ff @(posedge clk_i) begin
    o1_cx_q <= q_cx;
    o1_t_q  <= t_d;
    mx_q    <= mx_d;
    my_q    <= my_d;
  end

  // offset stage 2: half offset with sign of v, move centers, saturate
  logic [MW-1:0]      mxs, mys;
  logic signed [64:0] ox, oy;
  out_t               res_d, res_q;
  logic               o2_v_q;

  assign mxs = mx_q >> (FRAC_BITS + 1);
  assign mys = my_q >> (FRAC_BITS + 1);
  assign ox  = o1_cx_q.vx[32] ? -$signed({2'b0, mxs}) : $signed({2'b0, mxs});
  assign oy  = o1_cx_q.vy[32] ? -$signed({2'b0, mys}) : $signed({2'b0, mys});

  always_comb begin
    res_d.contact      = o1_cx_q.overlap || o1_cx_q.live;
    res_d.overlapping  = o1_cx_q.overlap;
    res_d.contact_time = o1_t_q;
    res_d.new_first_x  = sat32($signed({{33{o1_cx_q.p1x[31]}}, o1_cx_q.p1x}) - ox);
    res_d.new_first_y  = sat32($signed({{33{o1_cx_q.p1y[31]}}, o1_cx_q.p1y}) - oy);
    res_d.new_second_x = sat32($signed({{33{o1_cx_q.p2x[31]}}, o1_cx_q.p2x}) + ox);
    res_d.new_second_y = sat32($signed({{33{o1_cx_q.p2y[31]}}, o1_cx_q.p2y}) + oy);
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o1_v_q <= 1'b0;
      o2_v_q <= 1'b0;
    end else begin
      o1_v_q <= q_v;
      o2_v_q <= o1_v_q;
    end
  end

  assign done_o = o2_v_q;
  assign res_o  = res_q;

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// testbench for circle_pair_contact_resolve_top: directed and random circle pairs,
// scored against an exact wide-integer contact predictor; depends on cpcr_pkg
`timescale 1ns / 100ps
module testbench;
  import cpcr_pkg::*;

  localparam int FRAC = 16;
  localparam int NUM_RANDOM = 1300;
  localparam int DRAIN_CYCLES = 130;   // pipeline depth plus margin

  typedef logic [199:0] big_t;

  // expected-result store with an exact model of the resolver
  class contact_scoreboard;
    out_t pending[$];
    int   mismatches;

    function new();
      mismatches = 0;
    endfunction

    static function big_t mag_big(longint v);
      return big_t'(v < 0 ? -v : v);
    endfunction

    static function logic signed [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
    endfunction

    static function longint half_shift(longint vk, logic [63:0] t);
      logic [63:0] m;
      m = (64'(vk < 0 ? -vk : vk) * t) >> (FRAC + 1);
      return vk < 0 ? -longint'(m) : longint'(m);
    endfunction

    static function out_t resolve(in_t x);
      longint      sx, sy, vx, vy, ox, oy;
      big_t        ss, rr, c, a, bp, bn, bm, d, q, cand, num;
      logic [63:0] rs, t;
      out_t        r;
      sx = longint'(x.first_pos_x) - longint'(x.second_pos_x);
      sy = longint'(x.first_pos_y) - longint'(x.second_pos_y);
      vx = longint'(x.first_vel_x) - longint'(x.second_vel_x);
      vy = longint'(x.first_vel_y) - longint'(x.second_vel_y);
      rs = 64'(x.first_radius) + 64'(x.second_radius);
      r = '0;
      t = '0;
      ss = mag_big(sx) * mag_big(sx) + mag_big(sy) * mag_big(sy);
      rr = big_t'(rs) * big_t'(rs);
      if (ss < rr) begin
        r.contact = 1'b1;
        r.overlapping = 1'b1;
      end else begin
        c = ss - rr;
        a = mag_big(vx) * mag_big(vx) + mag_big(vy) * mag_big(vy);
        bp = '0;
        bn = '0;
        // signed dot product split into positive and negative parts
        if ((vx < 0) != (sx < 0) && vx != 0 && sx != 0) bn += mag_big(vx) * mag_big(sx);
        else bp += mag_big(vx) * mag_big(sx);
        if ((vy < 0) != (sy < 0) && vy != 0 && sy != 0) bn += mag_big(vy) * mag_big(sy);
        else bp += mag_big(vy) * mag_big(sy);
        if (bn > bp && a != 0) begin
          bm = bn - bp;
          if (bm * bm >= a * c) begin
            r.contact = 1'b1;
            d = bm * bm - a * c;
            q = '0;
            for (int i = 79; i >= 0; i--) begin
              cand = q;
              cand[i] = 1'b1;
              if (cand * cand <= d) q = cand;
            end
            num = (bm - q) << FRAC;
            if (num >= (a << 31)) t = 64'h7fffffff;
            else t = 64'(num / a);
          end
        end
      end
      r.contact_time = t[30:0];
      ox = half_shift(vx, t);
      oy = half_shift(vy, t);
      r.new_first_x  = clamp32(longint'(x.first_pos_x) - ox);
      r.new_first_y  = clamp32(longint'(x.first_pos_y) - oy);
      r.new_second_x = clamp32(longint'(x.second_pos_x) + ox);
      r.new_second_y = clamp32(longint'(x.second_pos_y) + oy);
      return r;
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatches++;
    endtask

    function void note_input(in_t x);
      pending = {pending, resolve(x)};
    endfunction

    task check_result(out_t got);
      out_t e;
      if (pending.size() == 0) begin
        report("result with no transaction outstanding");
      end else begin
        e = pending.pop_front();
        if (got.contact !== e.contact)
          report($sformatf("contact got %0b exp %0b", got.contact, e.contact));
        if (got.overlapping !== e.overlapping)
          report($sformatf("overlapping got %0b exp %0b", got.overlapping, e.overlapping));
        if (got.contact_time !== e.contact_time)
          report($sformatf("contact_time got %h exp %h", got.contact_time, e.contact_time));
        if (got.new_first_x !== e.new_first_x)
          report($sformatf("new_first_x got %h exp %h", got.new_first_x, e.new_first_x));
        if (got.new_first_y !== e.new_first_y)
          report($sformatf("new_first_y got %h exp %h", got.new_first_y, e.new_first_y));
        if (got.new_second_x !== e.new_second_x)
          report($sformatf("new_second_x got %h exp %h", got.new_second_x, e.new_second_x));
        if (got.new_second_y !== e.new_second_y)
          report($sformatf("new_second_y got %h exp %h", got.new_second_y, e.new_second_y));
      end
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  logic start_i;
  logic busy_o;
  in_t  in_i;
  logic done_o;
  out_t res_o;

  contact_scoreboard sb = new();

  circle_pair_contact_resolve_top #(.FRAC_BITS(FRAC)) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .in_i   (in_i),
    .done_o (done_o),
    .res_o  (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // sampled at the edge before any nonblocking update lands
  always @(posedge clk_i) begin
    if (rst_ni && start_i && !busy_o) sb.note_input(in_i);
    if (rst_ni && done_o) sb.check_result(res_o);
  end

  // mostly short gaps, now and then a long one, often none
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // holds start high until the block takes the transaction
  task automatic send_pair(in_t x);
    logic stalled;
    start_i <= 1'b1;
    in_i    <= x;
    do begin
      @(negedge clk_i);
      stalled = busy_o;
      @(posedge clk_i);
    end while (stalled);
  endtask

  task automatic send_with_gap(in_t x);
    int g;
    send_pair(x);
    g = pick_gap();
    if (g > 0) begin
      start_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  // random signed value of random magnitude
  function automatic logic [31:0] scaled_word();
    logic [31:0] w;
    w = $urandom >> $urandom_range(0, 31);
    return $urandom_range(0, 1) ? -w : w;
  endfunction

  function automatic in_t make_pair(longint p1x, longint p1y, longint v1x, longint v1y,
                                    longint r1, longint p2x, longint p2y, longint v2x,
                                    longint v2y, longint r2);
    in_t x;
    x.first_pos_x = p1x[31:0];  x.first_pos_y = p1y[31:0];
    x.first_vel_x = v1x[31:0];  x.first_vel_y = v1y[31:0];
    x.first_radius = r1[30:0];
    x.second_pos_x = p2x[31:0]; x.second_pos_y = p2y[31:0];
    x.second_vel_x = v2x[31:0]; x.second_vel_y = v2y[31:0];
    x.second_radius = r2[30:0];
    return x;
  endfunction

  // pair near each other, random velocities and radii
  function automatic in_t approach_pair();
    in_t x;
    x.first_pos_x = $urandom;
    x.first_pos_y = $urandom;
    x.second_pos_x = x.first_pos_x + scaled_word();
    x.second_pos_y = x.first_pos_y + scaled_word();
    x.first_vel_x = scaled_word();
    x.first_vel_y = scaled_word();
    x.second_vel_x = scaled_word();
    x.second_vel_y = scaled_word();
    x.first_radius = 31'($urandom >> $urandom_range(1, 31));
    x.second_radius = 31'($urandom >> $urandom_range(1, 31));
    return x;
  endfunction

  localparam longint ONE = 64'sd65536;
  localparam longint PMAX = 64'sd2147483647;
  localparam longint PMIN = -64'sd2147483648;
  localparam longint RMAX = 64'sd2147483647;

  initial begin
    in_t x;
    int  p;
    rst_ni  = 1'b0;
    start_i = 1'b0;
    in_i    = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed transactions
    send_with_gap('0);                                                        // all zero
    send_with_gap('1);                                                        // all ones
    send_with_gap(make_pair(0, 0, 0, 0, ONE, ONE, 0, 0, 0, ONE));             // overlap
    send_with_gap(make_pair(0, 0, ONE, 0, ONE, 2*ONE, 0, 0, 0, ONE));         // touching, approaching
    send_with_gap(make_pair(0, 0, -ONE, 0, ONE, 10*ONE, 0, 0, 0, ONE));       // moving apart
    send_with_gap(make_pair(0, 0, ONE, ONE, ONE, 10*ONE, 0, ONE, ONE, ONE));  // zero relative velocity
    send_with_gap(make_pair(0, 0, ONE, 0, ONE, 10*ONE, 0, -ONE, 0, ONE));     // head on
    send_with_gap(make_pair(0, 0, ONE, 0, ONE, 10*ONE, 50*ONE, 0, 0, ONE));   // miss, negative discriminant
    send_with_gap(make_pair(0, 0, 1, 0, 1, PMAX, 0, 0, 0, 1));                // time saturates
    send_with_gap(make_pair(PMIN, PMIN, PMAX, PMAX, 0, PMAX, PMAX, PMIN, PMIN, 0)); // huge offsets
    send_with_gap(make_pair(PMAX, PMAX, PMIN, PMIN, 0, PMIN, PMIN, PMAX, PMAX, 0));
    send_with_gap(make_pair(PMAX, 0, 0, 0, RMAX, PMIN, 0, 0, 0, RMAX));       // max radii
    send_with_gap(make_pair(PMIN, PMAX, PMAX, 0, 0, PMAX, PMIN, PMIN, 0, 1)); // position overflow
    send_with_gap(make_pair(0, 0, 3, -5, 7, 1000, -999, -2, 4, 9));           // tiny values
    send_with_gap(make_pair(0, 0, ONE, ONE, 0, 100*ONE, 100*ONE, 0, 0, 0));   // diagonal point contact
    send_with_gap(make_pair(-ONE, 0, PMAX, 0, 0, ONE, 0, PMIN, 0, 0));        // fast, zero radius

    // random part: mostly nearby pairs, some raw noise
    for (int n = 0; n < NUM_RANDOM; n++) begin
      p = $urandom_range(0, 99);
      if (p < 70) begin
        x = approach_pair();
      end else if (p < 85) begin
        x = in_t'(318'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom, $urandom, $urandom}));
      end else begin
        x = approach_pair();
        x.first_radius = 31'($urandom);   // often overlapping
      end
      send_with_gap(x);
    end
    start_i <= 1'b0;

    wait (sb.pending.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("** circle_pair_contact_resolve_top: PASSED **");
    end else begin
      $display("** circle_pair_contact_resolve_top: FAILED **");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5ms;
    $display("** circle_pair_contact_resolve_top: FAILED **");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/cpcr_pkg.sv
rtl/cpcr_front.sv
rtl/cpcr_sqrt.sv
rtl/cpcr_div.sv
rtl/circle_pair_contact_resolve_top.sv
tb/sv/testbench.sv
